/* hdl/murmur2_hash_32_defines.svh */
// Assertion macros shared by the murmur2_hash_32 modules.
`ifndef MURMUR2_HASH_32_DEFINES_SVH
`define MURMUR2_HASH_32_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define MH2_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define MH2_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/mh2_pkg.sv */
// Shared constants and queue entry type for the MurmurHash2 block.
package mh2_pkg;

    localparam logic [31:0] MIX_MUL     = 32'h5BD1E995;
    localparam int          MIX_SHIFT   = 24;
    localparam logic [31:0] SEED_RESET  = 32'd97;
    localparam int          FIN_SHIFT_A = 13;
    localparam int          FIN_SHIFT_B = 15;

    // request kinds
    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_FULL = 2'd1;
    localparam logic [1:0] KIND_TAIL = 2'd2;

    typedef struct packed {
        logic [31:0] init;   // seed ^ length
        logic [31:0] k;      // premixed full word
        logic [31:0] tail;   // masked tail bytes
        logic [1:0]  kind;
        logic        first;
        logic        last;
    } qentry_t;

endpackage

/* hdl/murmur2_hash_32.sv */
// Streaming MurmurHash2 32-bit: input request channel, seed register, hash output.
//
// Usage:
//   s_* carries one little-endian message word per request, with its byte
//   count (4 for a full word, 0..3 for a tail), first/last markers and the
//   total message length (sampled on the first word).
//   cfg_* writes the 32-bit seed; write it only while the block is idle.
//   m_* returns one hash per request marked last.
// Timing:
//   One request per cycle sustained while m_ready stays high. A last request's
//   hash appears on m_valid after word premix in the front-end registers s1 and
//   s2, one queue slot, the accumulator update (one multiply per request), then
//   the final mix through register b into the output register.
// Reset:
//   aresetn low clears all valid flags and the accumulator; the seed returns
//   to 97.
// Stall:
//   While m_ready is low the hash is held; the back end, queue and front end
//   fill in turn and s_ready drops once all are full.
module murmur2_hash_32 #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_data_word,
    input  logic [2:0]  s_byte_count,
    input  logic        s_first_word,
    input  logic        s_last_word,
    input  logic [31:0] s_message_length,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_hash_value
);
    import mh2_pkg::*;

    logic [31:0] seed_reg, seed_next;
    logic        push_valid, push_ready, pop_valid, pop_ready;
    qentry_t     push_entry, pop_entry;

    assign cfg_ready = 1'b1;
    assign seed_next = (cfg_valid && cfg_ready) ? cfg_data : seed_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg <= SEED_RESET;
        end else begin
            seed_reg <= seed_next;
        end
    end

    mh2_front u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_word      (s_data_word),
        .s_byte_count     (s_byte_count),
        .s_first_word     (s_first_word),
        .s_last_word      (s_last_word),
        .s_message_length (s_message_length),
        .hash_seed        (seed_reg),
        .push_valid       (push_valid),
        .push_ready       (push_ready),
        .push_entry       (push_entry)
    );

    mh2_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    mh2_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .pop_valid    (pop_valid),
        .pop_ready    (pop_ready),
        .pop_entry    (pop_entry),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_hash_value (m_hash_value)
    );

endmodule

/* hdl/mh2_front.sv */
// Front end: accepts requests, classifies them and premixes full words.
module mh2_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [31:0]      s_data_word,
    input  logic [2:0]       s_byte_count,
    input  logic             s_first_word,
    input  logic             s_last_word,
    input  logic [31:0]      s_message_length,
    input  logic [31:0]      hash_seed,
    output logic             push_valid,
    input  logic             push_ready,
    output mh2_pkg::qentry_t push_entry
);
    import mh2_pkg::*;

    logic    s1_valid_reg, s1_valid_next;
    qentry_t s1_reg, s1_next;
    logic    s2_valid_reg, s2_valid_next;
    qentry_t s2_reg, s2_next;

    logic        adv2;
    logic        accept;
    logic [31:0] tail_mask;
    logic [1:0]  kind;
    logic [31:0] k_mix;

    assign adv2    = !s2_valid_reg || push_ready;
    assign s_ready = !s1_valid_reg || adv2;
    assign accept  = s_valid && s_ready;

    always_comb begin
        unique case (s_byte_count[1:0])
            2'd1:    tail_mask = 32'h0000_00FF;
            2'd2:    tail_mask = 32'h0000_FFFF;
            2'd3:    tail_mask = 32'h00FF_FFFF;
            default: tail_mask = 32'h0000_0000;
        endcase
        if (s_byte_count[2]) begin
            kind = KIND_FULL;
        end else if (s_byte_count[1:0] == 2'd0) begin
            kind = KIND_NONE;
        end else begin
            kind = KIND_TAIL;
        end
    end

    always_comb begin
        s1_next       = s1_reg;
        s1_valid_next = s1_valid_reg;
        if (accept) begin
            s1_valid_next = 1'b1;
            s1_next.init  = hash_seed ^ s_message_length;
            s1_next.k     = s_data_word * MIX_MUL;
            s1_next.tail  = s_data_word & tail_mask;
            s1_next.kind  = kind;
            s1_next.first = s_first_word;
            s1_next.last  = s_last_word;
        end else if (adv2) begin
            s1_valid_next = 1'b0;
        end
    end

    // second half of the word mix
    assign k_mix = (s1_reg.k ^ (s1_reg.k >> MIX_SHIFT)) * MIX_MUL;

    always_comb begin
        s2_next       = s2_reg;
        s2_valid_next = s2_valid_reg;
        if (adv2) begin
            s2_valid_next = s1_valid_reg;
            s2_next       = s1_reg;
            s2_next.k     = k_mix;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
        s1_reg <= s1_next;
        s2_reg <= s2_next;
    end

    assign push_valid = s2_valid_reg;
    assign push_entry = s2_reg;

endmodule

/* hdl/mh2_fifo.sv */
// Short request queue between front and back ends.
`include "murmur2_hash_32_defines.svh"

module mh2_fifo #(
    parameter int DEPTH = 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push_valid,
    output logic             push_ready,
    input  mh2_pkg::qentry_t push_entry,
    output logic             pop_valid,
    input  logic             pop_ready,
    output mh2_pkg::qentry_t pop_entry
);
    import mh2_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    qentry_t       entries [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          push, pop;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_entry  = entries[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_IDX) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_IDX) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries[wr_ptr_reg] <= push_entry;
        end
    end

    `MH2_ASSERT_IMP(a_cnt_bound, aclk, aresetn, 1'b1, count_reg <= FULL_CNT, "queue overflow")
    `MH2_ASSERT_NXT(a_cnt_inc, aclk, aresetn, push && !pop, count_reg == $past(count_reg) + CW'(1), "count slip")

endmodule

/* hdl/mh2_back.sv */
// Back end: accumulator update, final mix and output register.
`include "murmur2_hash_32_defines.svh"

module mh2_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             pop_valid,
    output logic             pop_ready,
    input  mh2_pkg::qentry_t pop_entry,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [31:0]      m_hash_value
);
    import mh2_pkg::*;

    logic [31:0] acc_reg, acc_next;
    logic        a_valid_reg, a_valid_next;
    logic [31:0] a_hash_reg, a_hash_next;
    logic        b_valid_reg, b_valid_next;
    logic [31:0] b_hash_reg, b_hash_next;
    logic        m_valid_reg, m_valid_next;
    logic [31:0] m_hash_reg, m_hash_next;

    logic        pop, a_free, b_free, c_free, a_move, b_move;
    logic [31:0] h_base, operand, prod, h_new, fin_a;

    assign c_free    = !m_valid_reg || m_ready;
    assign b_free    = !b_valid_reg || c_free;
    assign a_free    = !a_valid_reg || b_free;
    assign b_move    = b_valid_reg && c_free;
    assign a_move    = a_valid_reg && b_free;
    assign pop_ready = a_free;
    assign pop       = pop_valid && pop_ready;

    assign h_base  = pop_entry.first ? pop_entry.init : acc_reg;
    assign operand = (pop_entry.kind == KIND_TAIL) ? (h_base ^ pop_entry.tail) : h_base;
    assign prod    = operand * MIX_MUL;

    always_comb begin
        unique case (pop_entry.kind)
            KIND_FULL: h_new = prod ^ pop_entry.k;
            KIND_TAIL: h_new = prod;
            default:   h_new = h_base;
        endcase
    end

    assign acc_next     = pop ? h_new : acc_reg;
    assign a_valid_next = (pop && pop_entry.last) || (a_valid_reg && !b_free);
    assign a_hash_next  = (pop && pop_entry.last) ? h_new : a_hash_reg;

    assign fin_a        = a_hash_reg ^ (a_hash_reg >> FIN_SHIFT_A);
    assign b_valid_next = a_move || (b_valid_reg && !c_free);
    assign b_hash_next  = a_move ? fin_a * MIX_MUL : b_hash_reg;

    assign m_valid_next = b_move || (m_valid_reg && !m_ready);
    assign m_hash_next  = b_move ? (b_hash_reg ^ (b_hash_reg >> FIN_SHIFT_B)) : m_hash_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg     <= '0;
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            acc_reg     <= acc_next;
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
            m_valid_reg <= m_valid_next;
        end
        a_hash_reg <= a_hash_next;
        b_hash_reg <= b_hash_next;
        m_hash_reg <= m_hash_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_hash_value = m_hash_reg;

    `MH2_ASSERT_NXT(a_last_fin, aclk, aresetn, pop && pop_entry.last, a_valid_reg, "last request lost")
    `MH2_ASSERT_NXT(a_none_hold, aclk, aresetn, pop && pop_entry.kind == KIND_NONE && !pop_entry.first, $stable(acc_reg), "empty request changed hash")
    `MH2_ASSERT_NXT(a_fin_out, aclk, aresetn, b_valid_reg && c_free, m_valid_reg, "finished hash dropped")

endmodule

/* tb/sv/murmur2_hash_32_checker.sv */
`timescale 1ns / 1ps
// Checker for murmur2_hash_32: follows seed writes, predicts each hash and compares results.
module murmur2_hash_32_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [31:0] s_data_word,
    input  logic [2:0]  s_byte_count,
    input  logic        s_first_word,
    input  logic        s_last_word,
    input  logic [31:0] s_message_length,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [31:0] cfg_data,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [31:0] m_hash_value,
    output int          fail_count,
    output int          hashes_pending
);

    localparam logic [31:0] MULT          = 32'h5BD1E995;
    localparam logic [31:0] SEED_AT_RESET = 32'd97;

    logic [31:0] seed;
    logic [31:0] running_hash;
    logic [31:0] hashes_due[$];

    function automatic logic [31:0] fold_request(input logic [31:0] h_in,
                                                 input logic [31:0] word,
                                                 input logic [2:0]  count);
        logic [31:0] h;
        logic [31:0] k;
        h = h_in;
        if (count >= 3'd4) begin
            k = word * MULT;
            k = k ^ (k >> 24);
            k = k * MULT;
            h = (h * MULT) ^ k;
        end else if (count != 3'd0) begin
            if (count == 3'd3)
                h = h ^ {8'h00, word[23:16], 16'h0000};
            if (count >= 3'd2)
                h = h ^ {16'h0000, word[15:8], 8'h00};
            h = (h ^ {24'h000000, word[7:0]}) * MULT;
        end
        return h;
    endfunction

    function automatic logic [31:0] finish_hash(input logic [31:0] h_in);
        logic [31:0] h;
        h = h_in ^ (h_in >> 13);
        h = h * MULT;
        return h ^ (h >> 15);
    endfunction

    always @(posedge aclk) begin : watch
        logic [31:0] h;
        logic [31:0] expected;
        if (!aresetn) begin
            seed         = SEED_AT_RESET;
            running_hash = 32'd0;
            hashes_due.delete();
        end else begin
            if (cfg_valid && cfg_ready)
                seed = cfg_data;
            if (m_valid && m_ready) begin
                if (hashes_due.size() == 0) begin
                    $error("hash_value: no result expected, actual %h", m_hash_value);
                    fail_count++;
                end else begin
                    expected = hashes_due.pop_front();
                    if (m_hash_value !== expected) begin
                        $error("hash_value: expected %h, actual %h", expected, m_hash_value);
                        fail_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                h = s_first_word ? (seed ^ s_message_length) : running_hash;
                h = fold_request(h, s_data_word, s_byte_count);
                running_hash = h;
                if (s_last_word)
                    hashes_due = {hashes_due, finish_hash(h)};
            end
        end
        hashes_pending = hashes_due.size();
    end

endmodule

/* tb/sv/murmur2_hash_32_tb.sv */
`timescale 1ns / 1ps
// Top of the murmur2_hash_32 testbench: clock, reset, request stimulus, seed writes, verdict.
module murmur2_hash_32_tb;

    localparam int PHASE_REQUESTS = 250;
    localparam int SETTLE_CYCLES  = 12;
    localparam int LONG_HOLD      = 300;
    localparam int STALL_LIMIT    = 4000;

    typedef enum int {
        SPOIL_WIDE_COUNT,
        SPOIL_SHORT_MID,
        SPOIL_NO_FIRST,
        SPOIL_BAD_LENGTH,
        SPOIL_NONE
    } spoil_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [31:0] s_data_word;
    logic [2:0]  s_byte_count;
    logic        s_first_word;
    logic        s_last_word;
    logic [31:0] s_message_length;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [31:0] cfg_data;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_hash_value;

    int fail_count;
    int hashes_pending;
    int requests_sent;
    int hold_asks;
    int holds_done;

    murmur2_hash_32 u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_word      (s_data_word),
        .s_byte_count     (s_byte_count),
        .s_first_word     (s_first_word),
        .s_last_word      (s_last_word),
        .s_message_length (s_message_length),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_hash_value     (m_hash_value)
    );

    murmur2_hash_32_checker u_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_word      (s_data_word),
        .s_byte_count     (s_byte_count),
        .s_first_word     (s_first_word),
        .s_last_word      (s_last_word),
        .s_message_length (s_message_length),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_hash_value     (m_hash_value),
        .fail_count       (fail_count),
        .hashes_pending   (hashes_pending)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // mostly short gaps, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // entered and left at a falling edge; valid stays up for a following request
    task automatic send_request(input logic [31:0] word, input logic [2:0] count,
                                input logic first, input logic last,
                                input logic [31:0] length, input bit steady);
        int gap;
        gap = steady ? 0 : idle_len();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid          <= 1'b1;
        s_data_word      <= word;
        s_byte_count     <= count;
        s_first_word     <= first;
        s_last_word      <= last;
        s_message_length <= length;
        do @(posedge aclk); while (!s_ready);
        requests_sent++;
        @(negedge aclk);
    endtask

    task automatic send_message(input bit broken);
        int unsigned nbytes;
        int unsigned words;
        int unsigned rest;
        int unsigned total;
        int unsigned spoil_at;
        int unsigned r;
        int unsigned i;
        logic [2:0]  count;
        logic [31:0] length;
        bit          steady;
        spoil_t      spoil;
        r = $urandom_range(0, 99);
        if (r < 70)
            nbytes = $urandom_range(0, 24);
        else if (r < 96)
            nbytes = $urandom_range(25, 64);
        else
            nbytes = $urandom_range(65, 160);
        words = nbytes / 4;
        rest  = nbytes % 4;
        total = words;
        if (rest != 0 || words == 0 || $urandom_range(0, 7) == 0)
            total++;
        length   = nbytes;
        steady   = ($urandom_range(0, 4) == 0);
        spoil    = broken ? spoil_t'($urandom_range(0, 3)) : SPOIL_NONE;
        spoil_at = $urandom_range(0, total - 1);
        if (spoil == SPOIL_BAD_LENGTH)
            length = $urandom;
        for (i = 0; i < total; i++) begin
            count = (i < words) ? 3'd4 : 3'(rest);
            if (spoil == SPOIL_WIDE_COUNT && i == spoil_at)
                count = 3'($urandom_range(5, 7));
            if (spoil == SPOIL_SHORT_MID && i == spoil_at)
                count = 3'($urandom_range(1, 3));
            send_request($urandom, count, (i == 0) && (spoil != SPOIL_NO_FIRST),
                         i == total - 1, length, steady);
        end
    endtask

    task automatic write_seed(input logic [31:0] value);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        @(negedge aclk);
        while (hashes_pending != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    initial begin : receiver
        int gap;
        m_ready    = 1'b0;
        holds_done = 0;
        forever begin
            @(negedge aclk);
            if (hold_asks != holds_done) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
                holds_done++;
                m_ready <= 1'b1;
            end else begin
                gap = idle_len();
                if (gap > 0) begin
                    m_ready <= 1'b0;
                    repeat (gap) @(negedge aclk);
                end
                m_ready <= 1'b1;
                if ($urandom_range(0, 9) == 0)
                    repeat ($urandom_range(30, 80)) @(negedge aclk);
                else
                    repeat ($urandom_range(0, 12)) @(negedge aclk);
            end
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial begin : stimulus
        logic [31:0] seeds[5];
        int          phase;
        int          phase_start;
        int          r;
        aresetn          = 1'b0;
        s_valid          = 1'b0;
        s_data_word      = 32'd0;
        s_byte_count     = 3'd0;
        s_first_word     = 1'b0;
        s_last_word      = 1'b0;
        s_message_length = 32'd0;
        cfg_valid        = 1'b0;
        cfg_data         = 32'd0;
        hold_asks        = 0;
        requests_sent    = 0;
        seeds[0] = 32'h0000_0000;
        seeds[1] = 32'hFFFF_FFFF;
        seeds[2] = $urandom;
        seeds[3] = $urandom;
        seeds[4] = $urandom;
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed requests under the reset seed
        send_request(32'h0000_0000, 3'd0, 1'b1, 1'b1, 32'd0, 0);
        send_request(32'hFFFF_FFFF, 3'd4, 1'b1, 1'b1, 32'hFFFF_FFFF, 0);
        send_request(32'h0000_0000, 3'd4, 1'b1, 1'b1, 32'd4, 1);
        send_request(32'h8000_0000, 3'd4, 1'b1, 1'b1, 32'h8000_0000, 1);
        send_request(32'hFFFF_FFA5, 3'd1, 1'b1, 1'b1, 32'd1, 0);
        send_request(32'hFFFF_5A3C, 3'd2, 1'b1, 1'b1, 32'd2, 0);
        send_request(32'hFF12_3456, 3'd3, 1'b1, 1'b1, 32'd3, 0);
        // counts above four act as full words
        send_request(32'h0102_0304, 3'd5, 1'b1, 1'b0, 32'd12, 1);
        send_request(32'hA5A5_5A5A, 3'd6, 1'b0, 1'b0, 32'd12, 1);
        send_request(32'hDEAD_BEEF, 3'd7, 1'b0, 1'b1, 32'd12, 1);
        // short word mid-message
        send_request(32'h1234_5678, 3'd2, 1'b1, 1'b0, 32'd6, 0);
        send_request(32'h9ABC_DEF0, 3'd4, 1'b0, 1'b1, 32'd6, 0);
        // no first marker, carries on from the accumulator
        send_request(32'h0F0F_0F0F, 3'd4, 1'b0, 1'b0, 32'd0, 0);
        send_request(32'hF0F0_F0F0, 3'd0, 1'b0, 1'b1, 32'hFFFF_FFFF, 0);
        // length disagrees with the bytes given
        send_request(32'h5555_5555, 3'd4, 1'b1, 1'b0, 32'd1000, 1);
        send_request(32'hAAAA_AAAA, 3'd4, 1'b0, 1'b0, 32'd1000, 1);
        send_request(32'h7777_77C3, 3'd1, 1'b0, 1'b1, 32'd1000, 1);
        // empty request mid-message
        send_request(32'hFFFF_FFFF, 3'd0, 1'b1, 1'b0, 32'd0, 0);
        send_request(32'h0000_0000, 3'd0, 1'b0, 1'b1, 32'd0, 0);
        s_valid <= 1'b0;

        for (phase = 0; phase < 5; phase++) begin
            drain();
            write_seed(seeds[phase]);
            if (phase == 1)
                hold_asks++;
            phase_start = requests_sent;
            while (requests_sent - phase_start < PHASE_REQUESTS) begin
                r = $urandom_range(0, 99);
                if (r < 82)
                    send_message(r < 10);
                else
                    send_request($urandom, 3'($urandom_range(0, 7)), 1'($urandom),
                                 1'($urandom), $urandom, 0);
            end
            s_valid <= 1'b0;
        end

        wait (hashes_pending == 0);
        repeat (20) @(posedge aclk);
        if (fail_count == 0 && hashes_pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

/* murmur2_hash_32.f */
+incdir+hdl
hdl/mh2_pkg.sv
hdl/mh2_front.sv
hdl/mh2_fifo.sv
hdl/mh2_back.sv
hdl/murmur2_hash_32.sv
tb/sv/murmur2_hash_32_checker.sv
tb/sv/murmur2_hash_32_tb.sv
